[rtl/core/lcs_pkg.sv]
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the longest common substring unit.
// ---------------------------------------------------------------------------
package lcs_pkg;

    // Field widths of a request and of a result.
    localparam int OPCODE_W  = 2;
    localparam int SYMBOL_W  = 8;
    localparam int LONGEST_W = 7;

    // Largest length the result port can carry; longer runs saturate.
    localparam logic [LONGEST_W-1:0] LONGEST_MAX = 7'd127;

    // Request opcodes as they arrive on the port.
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TEXT   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd2;
    // Opcode with no function; it is accepted and ignored.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Decoded command kind carried through the queue.
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SYMBOL_W-1:0]  symbol;
    } t_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/core/lcs_front.sv]
// ---------------------------------------------------------------------------
// lcs_front
// Accepts requests, decodes the opcode and drops unused codes.
// ---------------------------------------------------------------------------
module lcs_front (
    input  logic                          start,
    input  lcs_pkg::t_q_status            i_q_status,
    input  logic [lcs_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [lcs_pkg::SYMBOL_W-1:0]  i_symbol,
    output logic                          o_push,
    output lcs_pkg::t_cmd                 o_cmd
);

    logic           known;
    lcs_pkg::t_kind kind;

    // Decode the opcode; the unused code is accepted but goes nowhere.
    always_comb begin
        known = 1'b1;
        kind  = lcs_pkg::KIND_APPEND;
        unique case (i_opcode)
            lcs_pkg::OP_APPEND: kind = lcs_pkg::KIND_APPEND;
            lcs_pkg::OP_TEXT:   kind = lcs_pkg::KIND_TEXT;
            lcs_pkg::OP_FINISH: kind = lcs_pkg::KIND_FINISH;
            default:            known = 1'b0;
        endcase
    end

    // A request with a known opcode is pushed whenever the queue has room.
    assign o_push        = start && !i_q_status.full && known;
    assign o_cmd.kind    = kind;
    assign o_cmd.symbol  = i_symbol;

endmodule

[rtl/core/lcs_queue.sv]
// ---------------------------------------------------------------------------
// lcs_queue
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
module lcs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcs_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output lcs_pkg::t_cmd      o_cmd,
    output lcs_pkg::t_q_status o_status
);

    lcs_pkg::t_cmd r_entry [2];
    logic          r_head;
    logic          n_head;
    logic          r_tail;
    logic          n_tail;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_entry[r_head];

    // Pointer and fill count updates.
    always_comb begin
        n_head  = do_pop  ? ~r_head : r_head;
        n_tail  = do_push ? ~r_tail : r_tail;
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_tail] <= i_cmd;
        end
    end

endmodule

[rtl/core/lcs_back.sv]
// ---------------------------------------------------------------------------
// lcs_back
// Row of match cells, one per reference position, plus the running maximum.
// ---------------------------------------------------------------------------
module lcs_back #(
    parameter int MAX_LEN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_exec,
    input  lcs_pkg::t_cmd                  i_cmd,
    output logic                           o_done,
    output logic [lcs_pkg::LONGEST_W-1:0]  o_longest,
    output logic                           o_truncated
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > lcs_pkg::LONGEST_W) ? LW : lcs_pkg::LONGEST_W;

    logic [lcs_pkg::SYMBOL_W-1:0] r_ref [MAX_LEN];
    logic [LW-1:0]                r_run [MAX_LEN];
    logic [LW-1:0]                r_len;
    logic [LW-1:0]                r_best;
    logic                         r_over;
    logic                         r_done;
    logic [lcs_pkg::LONGEST_W-1:0] r_longest;
    logic                         r_truncated;

    logic                         is_append;
    logic                         is_text;
    logic                         is_finish;
    logic                         room;
    logic [MAX_LEN-1:0]           hit;
    logic [LW-1:0]                n_run [MAX_LEN];
    logic [CW-1:0]                best_ext;
    logic [lcs_pkg::LONGEST_W-1:0] best_sat;

    assign is_append = i_exec && (i_cmd.kind == lcs_pkg::KIND_APPEND);
    assign is_text   = i_exec && (i_cmd.kind == lcs_pkg::KIND_TEXT);
    assign is_finish = i_exec && (i_cmd.kind == lcs_pkg::KIND_FINISH);
    assign room      = (r_len < LW'(MAX_LEN));

    // Each cell extends the diagonal run on a match. A cell whose new run
    // passes the maximum must have had a diagonal equal to it, so the
    // maximum grows by at most one per text byte.
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic          valid;
        logic          match;
        logic [LW-1:0] diag;

        assign valid = (LW'(i) < r_len);
        assign match = (r_ref[i] == i_cmd.symbol);
        if (i == 0) begin : g_first
            assign diag = '0;
        end else begin : g_rest
            assign diag = r_run[i-1];
        end
        assign n_run[i] = match ? (diag + LW'(1)) : '0;
        assign hit[i]   = valid && match && (diag == r_best);

        // Run counters reset to zero, clear on finish and clear when their cell takes a new reference byte.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_run[i] <= '0;
            end else if (is_finish) begin
                r_run[i] <= '0;
            end else if (is_append && room && (r_len == LW'(i))) begin
                r_run[i] <= '0;
            end else if (is_text && valid) begin
                r_run[i] <= n_run[i];
            end
        end

        // Reference byte held by this cell.
        always_ff @(posedge i_clk) begin
            if (is_append && room && (r_len == LW'(i))) begin
                r_ref[i] <= i_cmd.symbol;
            end
        end
    end

    // Saturate the maximum to the result width.
    assign best_ext = CW'(r_best);
    assign best_sat = (best_ext > CW'(lcs_pkg::LONGEST_MAX)) ?
                      lcs_pkg::LONGEST_MAX : best_ext[lcs_pkg::LONGEST_W-1:0];

    // Length, maximum and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_best <= '0;
            r_over <= 1'b0;
        end else if (is_finish) begin
            r_len  <= '0;
            r_best <= '0;
            r_over <= 1'b0;
        end else if (is_append) begin
            if (room) begin
                r_len <= r_len + LW'(1);
            end else begin
                r_over <= 1'b1;
            end
        end else if (is_text && (|hit)) begin
            r_best <= r_best + LW'(1);
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= is_finish;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (is_finish) begin
            r_longest   <= best_sat;
            r_truncated <= r_over;
        end
    end

    assign o_done      = r_done;
    assign o_longest   = r_longest;
    assign o_truncated = r_truncated;

endmodule

[rtl/core/longest_common_substring_unit.sv]
// ---------------------------------------------------------------------------
// longest_common_substring_unit
// Length of the longest common substring of a reference and a text string.
// ---------------------------------------------------------------------------
// The unit takes one request per clock cycle: opcode 0 appends a reference
// byte, opcode 1 streams a text byte, opcode 2 emits the result and clears
// all state, opcode 3 is taken and ignored. A text byte updates every
// reference position at once in a row of MAX_LEN cells; a finish request
// passes through the command queue and the result register before its
// result shows on o_done. busy rises only when the two-entry
// command queue is full, which the back end never lets happen since it
// drains one command per cycle. Results are not held: the receiver must
// take o_longest and o_truncated in the cycle o_done is high.
module longest_common_substring_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lcs_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [lcs_pkg::SYMBOL_W-1:0]   i_symbol,
    output logic                           o_done,
    output logic [lcs_pkg::LONGEST_W-1:0]  o_longest,
    output logic                           o_truncated
);

    lcs_pkg::t_q_status q_status;
    lcs_pkg::t_cmd      push_cmd;
    lcs_pkg::t_cmd      head_cmd;
    logic               push;
    logic               exec;

    assign busy = q_status.full;
    assign exec = !q_status.empty;

    // Request decode.
    lcs_front u_front (
        .start      (start),
        .i_q_status (q_status),
        .i_opcode   (i_opcode),
        .i_symbol   (i_symbol),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Command queue.
    lcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (exec),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Cell row and result register.
    lcs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (exec),
        .i_cmd       (head_cmd),
        .o_done      (o_done),
        .o_longest   (o_longest),
        .o_truncated (o_truncated)
    );

`ifndef SYNTHESIS
    // A result follows only a finish command executed in the previous cycle.
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(exec && (head_cmd.kind == lcs_pkg::KIND_FINISH)))
        else $error("result without a finish command");

    // The queue status flags are never both set.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // A taken request with a known opcode is in the queue next cycle.
    a_request_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != lcs_pkg::OP_UNUSED)) |=> !q_status.empty)
        else $error("accepted request missing from queue");
`endif

endmodule
